>>> hw/rtl/rsf_pkg.sv
// Shared types and constants for the repeat suppression filter.
`default_nettype none

package rsf_pkg;

    typedef enum logic [1:0] {
        FUNC_VALUE   = 2'd0,
        FUNC_TICK    = 2'd1,
        FUNC_FLUSH   = 2'd2,
        FUNC_CONNECT = 2'd3
    } func_t;

    localparam logic REPEAT_FLAG = 1'b1;
    localparam logic [15:0] MAX_COUNT_RESET = 16'd100;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] sample_value;
        logic [63:0] sample_stamp;
        logic [63:0] host_time;
    } in_word_t;

    typedef struct packed {
        logic [63:0] out_value;
        logic [63:0] out_stamp;
        logic        out_is_repeat;
        logic [15:0] out_repeat_count;
        logic        out_last;
    } out_word_t;

    typedef struct packed {
        logic first;
        logic second;
    } res_valid_t;

endpackage

`default_nettype wire

>>> hw/rtl/rsf_step.sv
// Per-word decision logic: next filter state and up to two result words.
`default_nettype none

module rsf_step #(
    parameter int VALUE_BITS = 64,
    parameter int STAMP_BITS = 64,
    parameter int COUNT_BITS = 16
) (
    input  rsf_pkg::in_word_t    in_word,
    input  logic [15:0]          max_count,
    input  logic [VALUE_BITS-1:0] held_value,
    input  logic [STAMP_BITS-1:0] held_stamp,
    input  logic                 held_valid,
    input  logic [COUNT_BITS-1:0] tally,
    input  logic                 seen,
    input  logic                 last_was_rep,
    input  logic [STAMP_BITS-1:0] last_rep_stamp,
    output logic [VALUE_BITS-1:0] held_value_next,
    output logic [STAMP_BITS-1:0] held_stamp_next,
    output logic                 held_valid_next,
    output logic [COUNT_BITS-1:0] tally_next,
    output logic                 seen_next,
    output logic                 last_was_rep_next,
    output logic [STAMP_BITS-1:0] last_rep_stamp_next,
    output rsf_pkg::out_word_t   res0,
    output rsf_pkg::out_word_t   res1,
    output rsf_pkg::res_valid_t  res_valid
);

    localparam logic [COUNT_BITS-1:0] CEIL = {COUNT_BITS{1'b1}};

    rsf_pkg::func_t        func_sel;
    logic [VALUE_BITS-1:0] value_in;
    logic [STAMP_BITS-1:0] stamp_in;
    logic [STAMP_BITS-1:0] now_in;
    logic                  match;
    logic [COUNT_BITS-1:0] tally_inc;
    logic [31:0]           tally_w;
    logic [31:0]           tally_inc_w;
    logic                  count_emit;
    logic                  flush_emit;
    logic [STAMP_BITS-1:0] rep_now;
    logic [STAMP_BITS-1:0] rep_smp;
    logic [STAMP_BITS-1:0] lrs_eff;
    logic                  lwr_eff;
    logic [STAMP_BITS-1:0] new_stamp;
    rsf_pkg::out_word_t    pass_word;

    assign func_sel    = rsf_pkg::func_t'(in_word.func);
    assign value_in    = in_word.sample_value[VALUE_BITS-1:0];
    assign stamp_in    = in_word.sample_stamp[STAMP_BITS-1:0];
    assign now_in      = in_word.host_time[STAMP_BITS-1:0];
    assign match       = held_valid && (held_value == value_in);
    assign tally_inc   = (tally == CEIL) ? tally : tally + COUNT_BITS'(1);
    assign tally_w     = 32'(tally);
    assign tally_inc_w = 32'(tally_inc);
    assign count_emit  = held_valid && ((tally_inc_w >= 32'(max_count)) || (tally_inc == CEIL));
    assign flush_emit  = held_valid && (tally != '0);
    assign rep_now     = (now_in > held_stamp) ? now_in : held_stamp;
    assign rep_smp     = (stamp_in > held_stamp) ? stamp_in : held_stamp;
    assign lrs_eff     = flush_emit ? rep_smp : last_rep_stamp;
    assign lwr_eff     = flush_emit | last_was_rep;
    assign new_stamp   = (lwr_eff && (stamp_in < lrs_eff)) ? lrs_eff : stamp_in;

    always_comb begin
        pass_word                  = '0;
        pass_word.out_value        = 64'(value_in);
        pass_word.out_stamp        = 64'(new_stamp);
        pass_word.out_is_repeat    = 1'b0;
        pass_word.out_repeat_count = '0;
        pass_word.out_last         = 1'b1;
    end

    always_comb begin
        held_value_next     = held_value;
        held_stamp_next     = held_stamp;
        held_valid_next     = held_valid;
        tally_next          = tally;
        seen_next           = seen;
        last_was_rep_next   = last_was_rep;
        last_rep_stamp_next = last_rep_stamp;
        res0                = '0;
        res1                = '0;
        res_valid           = '0;
        res0.out_value      = 64'(held_value);
        res0.out_is_repeat  = rsf_pkg::REPEAT_FLAG;
        res0.out_last       = 1'b1;

        unique case (func_sel)
            rsf_pkg::FUNC_VALUE: begin
                if (match) begin
                    tally_next = tally_inc;
                    if (count_emit) begin
                        held_stamp_next        = rep_now;
                        last_was_rep_next      = 1'b1;
                        last_rep_stamp_next    = rep_now;
                        tally_next             = '0;
                        seen_next              = 1'b1;
                        res0.out_stamp         = 64'(rep_now);
                        res0.out_repeat_count  = tally_inc_w[15:0];
                        res_valid.first        = 1'b1;
                    end
                end else begin
                    held_value_next     = value_in;
                    held_stamp_next     = new_stamp;
                    held_valid_next     = 1'b1;
                    tally_next          = '0;
                    seen_next           = 1'b1;
                    last_was_rep_next   = 1'b0;
                    last_rep_stamp_next = lrs_eff;
                    res_valid.first     = 1'b1;
                    if (flush_emit) begin
                        res0.out_stamp        = 64'(rep_smp);
                        res0.out_repeat_count = tally_w[15:0];
                        res0.out_last         = 1'b0;
                        res1                  = pass_word;
                        res_valid.second      = 1'b1;
                    end else begin
                        res0 = pass_word;
                    end
                end
            end
            rsf_pkg::FUNC_TICK: begin
                if (seen) begin
                    seen_next = 1'b0;
                end else begin
                    tally_next = tally_inc;
                    if (count_emit) begin
                        held_stamp_next        = rep_now;
                        last_was_rep_next      = 1'b1;
                        last_rep_stamp_next    = rep_now;
                        tally_next             = '0;
                        seen_next              = 1'b1;
                        res0.out_stamp         = 64'(rep_now);
                        res0.out_repeat_count  = tally_inc_w[15:0];
                        res_valid.first        = 1'b1;
                    end
                end
            end
            rsf_pkg::FUNC_FLUSH: begin
                held_valid_next = 1'b0;
                if (flush_emit) begin
                    held_stamp_next        = rep_now;
                    last_was_rep_next      = 1'b1;
                    last_rep_stamp_next    = rep_now;
                    tally_next             = '0;
                    seen_next              = 1'b1;
                    res0.out_stamp         = 64'(rep_now);
                    res0.out_repeat_count  = tally_w[15:0];
                    res_valid.first        = 1'b1;
                end
            end
            rsf_pkg::FUNC_CONNECT: begin
                held_valid_next = 1'b0;
            end
            default: begin
                held_valid_next = held_valid;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/repeat_suppression_filter.sv
// Top level of the repeat suppression filter: state, output slot and pending slot.
//
// Input words arrive on s_valid/s_ready/s_word: a value sample, a scan tick,
// a flush, or a connect reset. Result words leave on m_valid/m_ready/m_word;
// out_last marks the final word caused by one input word.
// max_repeat_count is written through cfg_wr_en/cfg_wr_data while idle;
// the user must keep to this, as the block does not enforce it. The first
// result word of an input word is registered into the output register when
// that word is accepted. The filter accepts one input word per cycle while
// the receiver takes words; an input word that causes two results (repeat
// sample followed by a new value) holds the second in a pending slot, and
// input is held off until that slot drains. When the receiver stalls, the
// output register holds its word, s_ready drops and nothing is lost.
// Reset (aresetn low, synchronous) clears the held sample, the repeat tally,
// both output slots, and sets max_repeat_count to 100.
`default_nettype none

module repeat_suppression_filter #(
    parameter int VALUE_BITS = 64,
    parameter int STAMP_BITS = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  rsf_pkg::in_word_t   s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output rsf_pkg::out_word_t  m_word
);

    logic [15:0]           max_count_reg;
    logic [VALUE_BITS-1:0] held_value_reg;
    logic [STAMP_BITS-1:0] held_stamp_reg;
    logic                  held_valid_reg;
    logic [COUNT_BITS-1:0] tally_reg;
    logic                  seen_reg;
    logic                  last_was_rep_reg;
    logic [STAMP_BITS-1:0] last_rep_stamp_reg;

    logic [VALUE_BITS-1:0] held_value_next;
    logic [STAMP_BITS-1:0] held_stamp_next;
    logic                  held_valid_next;
    logic [COUNT_BITS-1:0] tally_next;
    logic                  seen_next;
    logic                  last_was_rep_next;
    logic [STAMP_BITS-1:0] last_rep_stamp_next;

    rsf_pkg::out_word_t    res0;
    rsf_pkg::out_word_t    res1;
    rsf_pkg::res_valid_t   res_valid;

    logic                  m_valid_reg;
    rsf_pkg::out_word_t    m_word_reg;
    logic                  pend_valid_reg;
    rsf_pkg::out_word_t    pend_word_reg;
    logic                  s_fire;

    rsf_step #(
        .VALUE_BITS (VALUE_BITS),
        .STAMP_BITS (STAMP_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .in_word             (s_word),
        .max_count           (max_count_reg),
        .held_value          (held_value_reg),
        .held_stamp          (held_stamp_reg),
        .held_valid          (held_valid_reg),
        .tally               (tally_reg),
        .seen                (seen_reg),
        .last_was_rep        (last_was_rep_reg),
        .last_rep_stamp      (last_rep_stamp_reg),
        .held_value_next     (held_value_next),
        .held_stamp_next     (held_stamp_next),
        .held_valid_next     (held_valid_next),
        .tally_next          (tally_next),
        .seen_next           (seen_next),
        .last_was_rep_next   (last_was_rep_next),
        .last_rep_stamp_next (last_rep_stamp_next),
        .res0                (res0),
        .res1                (res1),
        .res_valid           (res_valid)
    );

    assign s_ready = !pend_valid_reg && (!m_valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_count_reg      <= rsf_pkg::MAX_COUNT_RESET;
            held_value_reg     <= '0;
            held_stamp_reg     <= '0;
            held_valid_reg     <= 1'b0;
            tally_reg          <= '0;
            seen_reg           <= 1'b0;
            last_was_rep_reg   <= 1'b0;
            last_rep_stamp_reg <= '0;
            m_valid_reg        <= 1'b0;
            pend_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_count_reg <= cfg_wr_data;
            end
            if (s_fire) begin
                held_value_reg     <= held_value_next;
                held_stamp_reg     <= held_stamp_next;
                held_valid_reg     <= held_valid_next;
                tally_reg          <= tally_next;
                seen_reg           <= seen_next;
                last_was_rep_reg   <= last_was_rep_next;
                last_rep_stamp_reg <= last_rep_stamp_next;
                if (res_valid.first) begin
                    m_valid_reg    <= 1'b1;
                    m_word_reg     <= res0;
                    pend_valid_reg <= res_valid.second;
                    pend_word_reg  <= res1;
                end else begin
                    m_valid_reg <= m_valid_reg && !m_ready;
                end
            end else if (m_valid_reg && m_ready) begin
                // advance pending word into the output slot
                m_valid_reg    <= pend_valid_reg;
                m_word_reg     <= pend_word_reg;
                pend_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
